/* design/dis_pkg.sv */
// Shared constants, types and helpers for the distinct index sampler.
package dis_pkg;

  localparam int MAX_SET    = 4096;
  localparam int MAX_SELECT = 64;
  localparam int MAX_WORDS  = 64;

  localparam int ADDR_W    = $clog2(MAX_SET);
  localparam int IDX_W     = 12;
  localparam int WORD_W    = 64;
  localparam int SEL_W     = 7;
  localparam int SIZE_W    = 13;
  localparam int CBITS_W   = 4;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CAND_W    = 1 << CBITS_W;
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int EMIT_W    = $clog2(MAX_SELECT + 1);

  // Queue geometry shared by the candidate queue and the result queue
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SELECT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CBITS  = CFG_IDX_W'(2);

  // Run settings derived from the registers
  typedef struct packed {
    logic [SEL_W-1:0]   k;
    logic [SIZE_W-1:0]  kp;
    logic               pick;
    logic               possible;
    logic [SIZE_W-1:0]  need;
    logic [ADDR_W-1:0]  last_addr;
    logic [CBITS_W-1:0] cbits;
  } run_cfg_t;

  // One classified word: mark is set when the candidate may be marked
  typedef struct packed {
    logic              mark;
    logic [ADDR_W-1:0] idx;
  } cand_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
    logic             failed;
  } res_t;

  function automatic run_cfg_t derive_cfg(input logic [SEL_W-1:0]   sel,
                                          input logic [SIZE_W-1:0]  size,
                                          input logic [CBITS_W-1:0] cbits);
    run_cfg_t          c;
    logic [SIZE_W-1:0] k_ext;
    c.k = sel;
    if (sel == '0) begin
      c.k = SEL_W'(1);
    end else if (sel > SEL_W'(MAX_SELECT)) begin
      c.k = SEL_W'(MAX_SELECT);
    end
    c.kp        = (size > SIZE_W'(MAX_SET)) ? SIZE_W'(MAX_SET) : size;
    k_ext       = SIZE_W'(c.k);
    c.pick      = k_ext <= (c.kp >> 1);
    c.possible  = c.kp > k_ext;
    c.need      = c.pick ? k_ext : (c.possible ? c.kp - k_ext : '0);
    c.last_addr = ADDR_W'(c.kp - SIZE_W'(1));
    c.cbits     = cbits;
    return c;
  endfunction

endpackage

/* design/distinct_index_sampler.sv */
// Top level of the distinct index sampler: registers, front end, back end, result queue.
//
// Picks select_count distinct indices below set_size from a stream of 64-bit
// random words and returns them in ascending order, run_last high on the final
// one. Each word's low candidate_bits bits are a candidate; candidates at or
// above set_size are dropped. Words are taken one per cycle while full is low
// into a four-entry queue; the back end retires a queued word in a bitmap
// read step and then a conditional bitmap write step, and takes no new word
// until it is through with the last one. When a run completes, the back end scans
// the 4096-bit bitmap memory from index 0 to set_size-1, one bit per cycle
// while the result queue has room, clearing it as it goes; words keep queueing
// meanwhile. If 64 words go by without completion, a single result with
// chosen_index 0, run_last and failed high is returned, followed by a clearing
// sweep from index 0 to set_size-1 (skipped when set_size does not exceed
// select_count). After reset and after every write to a valid register index
// the whole bitmap is cleared, during which full stays high. Such a write
// abandons the run in progress without any result.
module distinct_index_sampler import dis_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // word requests
  input  logic                 push,
  output logic                 full,
  input  logic [WORD_W-1:0]    random_word,
  // result requests
  output logic                 empty,
  input  logic                 pop,
  output logic [IDX_W-1:0]     chosen_index,
  output logic                 run_last,
  output logic                 failed,
  // register writes
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [SEL_W-1:0]   select_count;
  logic [SIZE_W-1:0]  set_size;
  logic [CBITS_W-1:0] candidate_bits;

  logic     cfg_clear;
  run_cfg_t run_cfg;
  cand_t    q_head;
  logic     q_empty;
  logic     q_pop;
  logic     booting;
  logic     res_space;
  logic     res_push;
  res_t     res;
  res_t     res_head;

  // writes beyond the register list are ignored and leave the run alone
  assign cfg_clear = cfg_write && (cfg_index == REG_SELECT || cfg_index == REG_SIZE ||
                                   cfg_index == REG_CBITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      select_count   <= SEL_W'(32);
      set_size       <= SIZE_W'(4096);
      candidate_bits <= CBITS_W'(12);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SELECT: select_count   <= cfg_data[SEL_W-1:0];
        REG_SIZE:   set_size       <= cfg_data[SIZE_W-1:0];
        REG_CBITS:  candidate_bits <= cfg_data[CBITS_W-1:0];
        default:    ;
      endcase
    end
  end

  // clamped select/set sizes, mode and target mark count
  assign run_cfg = derive_cfg(select_count, set_size, candidate_bits);

  dis_front u_front (
    .clk         (clk),
    .rst         (rst),
    .flush       (cfg_clear),
    .blocked     (booting),
    .cfg         (run_cfg),
    .push        (push),
    .random_word (random_word),
    .full        (full),
    .q_pop       (q_pop),
    .q_head      (q_head),
    .q_empty     (q_empty)
  );

  dis_back u_back (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_clear),
    .cfg       (run_cfg),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res_space (res_space),
    .res_push  (res_push),
    .res       (res),
    .booting   (booting)
  );

  dis_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .data  (res),
    .space (res_space),
    .pop   (pop),
    .empty (empty),
    .head  (res_head)
  );

  assign chosen_index = res_head.index;
  assign run_last     = res_head.last;
  assign failed       = res_head.failed;

endmodule

/* design/dis_front.sv */
// Front end: takes words, extracts and range-checks the candidate, queues it.
module dis_front import dis_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              flush,
  input  logic              blocked,
  input  run_cfg_t          cfg,
  input  logic              push,
  input  logic [WORD_W-1:0] random_word,
  output logic              full,
  input  logic              q_pop,
  output cand_t             q_head,
  output logic              q_empty
);

  logic [CAND_W-1:0]  cand;
  logic [CAND_W-1:0]  cand_mask;
  cand_t              entry;
  logic               take;

  cand_t              q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  // low cbits of the word; the wider bits never reach the candidate
  assign cand_mask  = (CAND_W'(1) << cfg.cbits) - CAND_W'(1);
  assign cand       = random_word[CAND_W-1:0] & cand_mask;
  assign entry.mark = cfg.possible && (cand < CAND_W'(cfg.kp));
  assign entry.idx  = cand[ADDR_W-1:0];

  assign full    = (count == Q_CNT_W'(Q_DEPTH)) || blocked;
  assign take    = push && !full;
  assign q_empty = (count == '0);
  assign q_head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      case ({take, q_pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q[wr_ptr] <= entry;
    end
  end

endmodule

/* design/dis_back.sv */
// Back end: bitmap marking, ascending scan, clearing sweeps.
module dis_back import dis_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     clear,
  input  run_cfg_t cfg,
  input  cand_t    q_head,
  input  logic     q_empty,
  output logic     q_pop,
  input  logic     res_space,
  output logic     res_push,
  output res_t     res,
  output logic     booting
);

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_FETCH = 5'b00010,
    S_TEST  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_SWEEP = 5'b10000
  } back_state_t;

  back_state_t       state, state_next;
  logic [ADDR_W-1:0] addr, addr_next;
  cand_t             cur, cur_next;
  logic [CNT_W-1:0]  marked, marked_next;
  logic [CNT_W-1:0]  words, words_next;
  logic [EMIT_W-1:0] emitted, emitted_next;
  logic              pend, pend_next;
  logic [ADDR_W-1:0] pend_addr;
  logic [CNT_W-1:0]  marked_inc;
  logic [CNT_W-1:0]  words_inc;

  logic              map_mem [MAX_SET];
  logic              map_rd;
  logic              map_we;
  logic [ADDR_W-1:0] map_waddr;
  logic              map_wdata;
  logic [ADDR_W-1:0] map_raddr;

  assign booting = (state == S_INIT);

  // read-before-write: a scan read clears the same bit in the same cycle
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rd <= map_mem[map_raddr];
  end

  always_comb begin
    state_next   = state;
    addr_next    = addr;
    cur_next     = cur;
    marked_next  = marked;
    words_next   = words;
    emitted_next = emitted;
    pend_next    = 1'b0;
    marked_inc   = marked;
    words_inc    = words + CNT_W'(1);
    map_we       = 1'b0;
    map_waddr    = addr;
    map_wdata    = 1'b0;
    map_raddr    = addr;
    q_pop        = 1'b0;
    res_push     = 1'b0;
    res          = '0;

    // scan data back from the bitmap
    if (pend && (map_rd == cfg.pick) && (SEL_W'(emitted) < cfg.k)) begin
      res_push     = 1'b1;
      res.index    = IDX_W'(pend_addr);
      res.last     = (SEL_W'(emitted + EMIT_W'(1)) == cfg.k);
      res.failed   = 1'b0;
      emitted_next = emitted + EMIT_W'(1);
    end

    case (state)
      S_INIT: begin
        map_we    = 1'b1;
        addr_next = addr + ADDR_W'(1);
        if (addr == ADDR_W'(MAX_SET - 1)) begin
          addr_next  = '0;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (!q_empty && res_space) begin
          q_pop      = 1'b1;
          cur_next   = q_head;
          map_raddr  = q_head.idx;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (cur.mark && !map_rd) begin
          map_we     = 1'b1;
          map_waddr  = cur.idx;
          map_wdata  = 1'b1;
          marked_inc = marked + CNT_W'(1);
        end
        if (cfg.possible && (SIZE_W'(marked_inc) >= cfg.need)) begin
          marked_next  = '0;
          words_next   = '0;
          emitted_next = '0;
          addr_next    = '0;
          state_next   = S_SCAN;
        end else if (words_inc >= CNT_W'(MAX_WORDS)) begin
          res_push     = 1'b1;
          res.index    = '0;
          res.last     = 1'b1;
          res.failed   = 1'b1;
          marked_next  = '0;
          words_next   = '0;
          addr_next    = '0;
          // no marks exist when the run was never possible
          state_next   = cfg.possible ? S_SWEEP : S_FETCH;
        end else begin
          marked_next = marked_inc;
          words_next  = words_inc;
          state_next  = S_FETCH;
        end
      end
      S_SCAN: begin
        if (res_space) begin
          map_we    = 1'b1;
          pend_next = 1'b1;
          addr_next = addr + ADDR_W'(1);
          if (addr == cfg.last_addr) begin
            addr_next  = '0;
            state_next = S_FETCH;
          end
        end
      end
      S_SWEEP: begin
        map_we    = 1'b1;
        addr_next = addr + ADDR_W'(1);
        if (addr == cfg.last_addr) begin
          addr_next  = '0;
          state_next = S_FETCH;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state   <= S_INIT;
      addr    <= '0;
      marked  <= '0;
      words   <= '0;
      emitted <= '0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      addr    <= addr_next;
      marked  <= marked_next;
      words   <= words_next;
      emitted <= emitted_next;
      pend    <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    pend_addr <= addr;
  end

  a_marks_le_words: assert property (@(posedge clk) disable iff (rst)
    marked <= words) else $error("more marks than words in a run");

  a_words_bound: assert property (@(posedge clk) disable iff (rst)
    words < CNT_W'(MAX_WORDS)) else $error("word count ran past the limit");

  a_set_in_test: assert property (@(posedge clk) disable iff (rst)
    (map_we && map_wdata) |-> (state == S_TEST))
    else $error("bitmap set outside the mark step");

  a_scan_count: assert property (@(posedge clk) disable iff (rst || clear)
    ((state == S_SCAN) && (state_next == S_FETCH)) |-> ##2 (SEL_W'(emitted) == cfg.k))
    else $error("scan did not emit exactly select_count indices");

endmodule

/* design/dis_outq.sv */
// Result queue between the back end and the result ports.
module dis_outq import dis_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t data,
  output logic space,
  input  logic pop,
  output logic empty,
  output res_t head
);

  res_t               q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               take;

  // two free slots: room for a new request plus one already in flight
  assign space = (count <= Q_CNT_W'(Q_DEPTH - 2));
  assign empty = (count == '0);
  assign take  = pop && !empty;
  assign head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      case ({push, take})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != Q_CNT_W'(Q_DEPTH))) else $error("result queue overflow");

endmodule

/* tb/tb_distinct_index_sampler.sv */
// Testbench for distinct_index_sampler: directed table plus random runs, self-checked.
`timescale 1ns / 1ps

module tb_distinct_index_sampler;
  import dis_pkg::*;

  // Register index that names no register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  // Pause before a register write: a full bitmap sweep plus a drained word queue
  localparam int SETTLE      = MAX_SET + 200;
  // Worst quiet stretch is about one settle pause plus a sweep; allow several times that
  localparam int QUIET_LIMIT = 40000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_DIR       = 28;

  localparam res_t NO_PICK = '0;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  // One line of the directed table: a register write or a word (repeated reps times).
  // has_pick marks rows whose single result is written out by hand; it applies to
  // the last repetition only.
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [CFG_W-1:0]     reg_val;
    logic [WORD_W-1:0]    word;
    logic [6:0]           reps;
    logic                 has_pick;
    res_t                 pick;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [WORD_W-1:0]    random_word = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [IDX_W-1:0]     chosen_index;
  logic                 run_last;
  logic                 failed;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  distinct_index_sampler u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .random_word  (random_word),
    .empty        (empty),
    .pop          (pop),
    .chosen_index (chosen_index),
    .run_last     (run_last),
    .failed       (failed),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: register copies and the run in progress
  // ---------------------------------------------------------------------------
  logic [SEL_W-1:0]   cfg_select = SEL_W'(32);
  logic [SIZE_W-1:0]  cfg_size   = SIZE_W'(4096);
  logic [CBITS_W-1:0] cfg_cbits  = CBITS_W'(12);
  bit                 idx_seen [MAX_SET];
  int unsigned        marked_cnt = 0;
  int unsigned        words_cnt  = 0;

  res_t pending_picks[$];   // expected results, oldest first
  res_t drawn[$];           // results of the word just taken
  res_t want;

  int fail_cnt     = 0;
  int quiet_cycles = 0;

  // Sender/receiver controls, set by the stimulus thread
  int   gap_pct       = 0;
  int   stall_pct     = 0;
  bit   hold_req      = 1'b0;
  int   hold_left     = 0;
  bit   table_pick_on = 1'b0;
  res_t table_pick    = '0;

  dir_row_t dir_tab [N_DIR];

  function automatic void reset_run();
    foreach (idx_seen[i]) idx_seen[i] = 1'b0;
    marked_cnt = 0;
    words_cnt  = 0;
  endfunction

  // Register write: any known index abandons the run; the spare index does nothing
  function automatic void set_reg(input logic [CFG_IDX_W-1:0] sel,
                                  input logic [CFG_W-1:0] val);
    case (sel)
      REG_SELECT: cfg_select = val[SEL_W-1:0];
      REG_SIZE:   cfg_size   = val[SIZE_W-1:0];
      REG_CBITS:  cfg_cbits  = val[CBITS_W-1:0];
      default: ;
    endcase
    if (sel != REG_UNUSED) reset_run();
  endfunction

  // Takes one random word; leaves whatever results it causes in drawn
  function automatic void sample_indices(input logic [WORD_W-1:0] w);
    int unsigned k;
    int unsigned kp;
    int unsigned need;
    int unsigned cand;
    int unsigned n;
    bit          pick;
    bit          possible;
    k  = cfg_select;
    kp = cfg_size;
    if (k == 0) k = 1;
    if (k > MAX_SELECT) k = MAX_SELECT;
    if (kp > MAX_SET) kp = MAX_SET;
    pick     = (k <= kp / 2);
    possible = (kp > k);
    // pick mode marks chosen indices, otherwise the rejected ones are marked
    need = pick ? k : (possible ? kp - k : 0);
    cand = int'(w & ((64'd1 << cfg_cbits) - 64'd1));
    words_cnt++;
    drawn.delete();
    if (possible && cand < kp && !idx_seen[cand]) begin
      idx_seen[cand] = 1'b1;
      marked_cnt++;
    end
    if (possible && marked_cnt >= need) begin
      n = 0;
      for (int i = 0; i < kp && n < k; i++) begin
        if (idx_seen[i] == pick) begin
          drawn.push_back('{index: IDX_W'(i), last: 1'b0, failed: 1'b0});
          n++;
        end
      end
      if (n > 0) drawn[n-1].last = 1'b1;
      reset_run();
    end else if (words_cnt >= MAX_WORDS) begin
      drawn.push_back('{index: '0, last: 1'b1, failed: 1'b1});
      reset_run();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge; inputs move at the falling one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      reset_run();
    end else begin
      if (cfg_write) set_reg(cfg_index, cfg_data);
      if (push && !full) begin
        sample_indices(random_word);
        // a hand-written row replaces what the predictor says for that word
        if (table_pick_on) pending_picks.push_back(table_pick);
        else foreach (drawn[i]) pending_picks.push_back(drawn[i]);
      end
      if (pop && !empty) begin
        if (pending_picks.size() == 0) begin
          $error("result with none expected: chosen_index %0d run_last %0b failed %0b",
                 chosen_index, run_last, failed);
          fail_cnt++;
        end else begin
          want = pending_picks.pop_front();
          if (chosen_index !== want.index) begin
            $error("chosen_index: expected %0d, got %0d", want.index, chosen_index);
            fail_cnt++;
          end
          if (run_last !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, run_last);
            fail_cnt++;
          end
          if (failed !== want.failed) begin
            $error("failed: expected %0b, got %0b", want.failed, failed);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which no request of any kind goes through
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off counted here on request
  always @(negedge clk) begin
    if (rst) begin
      pop = 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else begin
        pop = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; each is entered and left just after a falling edge
  // ---------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offers one word request; push stays high into the next call for back-to-back
  task automatic offer_word(input logic [WORD_W-1:0] w, input bit hand_pick,
                            input res_t hand_res);
    while ($urandom_range(99) < gap_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push          = 1'b1;
    random_word   = w;
    table_pick_on = hand_pick;
    table_pick    = hand_res;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_picks();
    push = 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
  endtask

  // Writes wait for an idle block: all results in, then a sweep's worth of cycles
  // in case words without results are still being worked off
  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] val);
    drain_picks();
    repeat (SETTLE) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = sel;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    int unsigned       kp_pick;
    int unsigned       base;
    int unsigned       stride;
    logic [WORD_W-1:0] w;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. Rows 0-1 run under reset settings and are abandoned by the
    // first write. Then k=1 over {0,1}: top bits ignored, out-of-range word dropped,
    // zero and oversized candidate widths, select 0 read as 1, duplicate and
    // out-of-range candidates, the spare register index, the marking-rejects mode
    // (k=3 of 4), and an impossible set size that fails after the word limit.
    dir_tab = '{
      '{ROW_WORD, REG_SELECT, 13'd0,    64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    '1,                    7'd1,  1'b0, NO_PICK},
      '{ROW_REG,  REG_SELECT, 13'd1,    64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_REG,  REG_SIZE,   13'd2,    64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    64'hFFFF_FFFF_FFFF_F000, 7'd1, 1'b1,
        '{IDX_W'(0), 1'b1, 1'b0}},
      '{ROW_WORD, REG_SELECT, 13'd0,    '1,                    7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    64'h1,                 7'd1,  1'b1,
        '{IDX_W'(1), 1'b1, 1'b0}},
      '{ROW_REG,  REG_CBITS,  13'd0,    64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    '1,                    7'd1,  1'b1,
        '{IDX_W'(0), 1'b1, 1'b0}},
      '{ROW_REG,  REG_CBITS,  13'd15,   64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    64'h8001,              7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    64'hAAAA_AAAA_AAAA_0001, 7'd1, 1'b1,
        '{IDX_W'(1), 1'b1, 1'b0}},
      '{ROW_REG,  REG_CBITS,  13'd12,   64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_REG,  REG_SELECT, 13'd0,    64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    64'h5555_5555_5555_5000, 7'd1, 1'b1,
        '{IDX_W'(0), 1'b1, 1'b0}},
      '{ROW_REG,  REG_SELECT, 13'd2,    64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_REG,  REG_SIZE,   13'd8,    64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    64'h5,                 7'd1,  1'b0, NO_PICK},
      '{ROW_REG,  REG_UNUSED, 13'h1FFF, 64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    64'h5,                 7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    64'hD,                 7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_REG,  REG_SELECT, 13'd3,    64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_REG,  REG_SIZE,   13'd4,    64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    64'h2,                 7'd1,  1'b0, NO_PICK},
      '{ROW_REG,  REG_SELECT, 13'd2,    64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_REG,  REG_SIZE,   13'd2,    64'h0,                 7'd1,  1'b0, NO_PICK},
      '{ROW_WORD, REG_SELECT, 13'd0,    '1,                    7'(MAX_WORDS), 1'b1,
        '{IDX_W'(0), 1'b1, 1'b1}}
    };

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_REG) begin
        write_reg(dir_tab[r].reg_sel, dir_tab[r].reg_val);
      end else begin
        for (int j = 0; j < dir_tab[r].reps; j++)
          offer_word(dir_tab[r].word, dir_tab[r].has_pick && (j == dir_tab[r].reps - 1),
                     dir_tab[r].pick);
      end
    end
    table_pick_on = 1'b0;

    // Random phases, each with its own settings and idling mode
    for (int ph = 0; ph < 7; ph++) begin
      case (ph % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 57;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 57;
        end
        default: begin
          gap_pct   = 7;
          stall_pct = 7;
        end
      endcase

      case (ph)
        0: begin
          // one result per word; a long hold-off fills both queues and stalls push.
          // The first word waits out the bitmap clear, so the hold starts after it.
          write_reg(REG_SELECT, CFG_W'(1));
          write_reg(REG_SIZE, CFG_W'(2));
          write_reg(REG_CBITS, CFG_W'(1));
          offer_word(rand_word(), 1'b0, NO_PICK);
          hold_req = 1'b1;
          repeat (11) offer_word(rand_word(), 1'b0, NO_PICK);
        end
        1: begin
          // saturated k=64 over the full set: distinct candidates by an odd stride,
          // so the run completes exactly on the last allowed word
          write_reg(REG_SELECT, CFG_W'(127));
          write_reg(REG_SIZE, CFG_W'(8191));
          write_reg(REG_CBITS, CFG_W'(12));
          base   = $urandom_range(MAX_SET - 1);
          stride = 2 * $urandom_range(MAX_SET / 2 - 1) + 1;
          for (int i = 0; i < MAX_WORDS; i++) begin
            w        = rand_word();
            w[11:0]  = 12'(base + i * stride);
            offer_word(w, 1'b0, NO_PICK);
          end
        end
        2: begin
          // 64 of 65: marks rejects, one in-range word ends a run with 64 results
          write_reg(REG_SELECT, CFG_W'(64));
          write_reg(REG_SIZE, CFG_W'(65));
          write_reg(REG_CBITS, CFG_W'(7));
          repeat (6) offer_word(rand_word(), 1'b0, NO_PICK);
        end
        default: begin
          // small sets; mostly in-range candidates, some raw noise words
          kp_pick = $urandom_range(40, 2);
          write_reg(REG_SIZE, CFG_W'(kp_pick));
          write_reg(REG_SELECT, CFG_W'($urandom_range(kp_pick - 1, 1)));
          if ($urandom_range(3) == 0) write_reg(REG_CBITS, CFG_W'($urandom_range(15)));
          else write_reg(REG_CBITS, CFG_W'($clog2(kp_pick)));
          for (int i = 0; i < 6; i++) begin
            // halfway through, the sender waits for every result to come back
            if (i == 3) drain_picks();
            w = rand_word();
            if ($urandom_range(4) != 0) w[15:0] = 16'($urandom_range(kp_pick - 1));
            offer_word(w, 1'b0, NO_PICK);
          end
        end
      endcase
    end

    drain_picks();
    repeat (SETTLE) @(negedge clk);
    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
